/* rtl/core/best_fit_bin_allocator_assert.svh */
// assertion macros for the best-fit bin allocator
`ifndef BEST_FIT_BIN_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_BIN_ALLOCATOR_ASSERT_SVH

// consequence checked in the same cycle as the trigger
`define BFBA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequence checked in the cycle after the trigger
`define BFBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/bfba_pkg.sv */
// shared types and constants of the best-fit bin allocator
package bfba_pkg;

  localparam int MAX_BINS_DEF = 16;

  localparam int COUNT_W   = 5;
  localparam int CAP_W     = 40;
  localparam int LEN_W     = 32;
  localparam int BIN_OUT_W = 4;
  localparam int LEFT_W    = 41;
  localparam int DIFF_W    = 42;
  localparam int CFG_IDX_W = 2;

  localparam logic [COUNT_W-1:0] BIN_COUNT_RST = 5'd4;

  // lowest remaining capacity a bin can hold
  localparam logic signed [DIFF_W-1:0] REM_MIN =
    {{(DIFF_W-CAP_W){1'b1}}, {CAP_W{1'b0}}};

  localparam logic ACT_CLEAR       = 1'b0;
  localparam logic ACT_PLACE       = 1'b1;
  localparam logic PLACED_BEST     = 1'b0;
  localparam logic PLACED_FALLBACK = 1'b1;
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_OVERSIZE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIN_COUNT    = 2'd0,
    CFG_BIN_CAPACITY = 2'd1,
    CFG_SLACK_LIMIT  = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_CLEAR,
    ST_SCAN,
    ST_DRAIN,
    ST_WB,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load_item;
    logic cnt_clr;
    logic clr_wr;
    logic scan_init;
    logic scan_rd;
    logic wb;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic oversize;
    logic cnt_last;
    logic out_free;
  } sts_t;

endpackage

/* rtl/core/best_fit_bin_allocator.sv */
// top level of the best-fit bin allocator
//
// channel   direction  handshake            word
// in_       input      in_valid/in_ready    in_action, in_item_length
// out_      output     out_valid/out_ready  out_assigned_bin, out_placed_by,
//                                           out_status, out_capacity_left
// cfg_      input      cfg_we (no wait)     cfg_index, cfg_wdata
//
// one word at a time; a place word raises out_valid after a decide step, a scan of the
// n active bins (one bin per cycle from the bin store), a drain, a write-back and a result step
// a clear word writes each active bin once; an oversize word goes straight to the result step
// the next word is accepted in the cycle after the result is loaded,
// even while out_ready is low; a second result then waits in the controller
// synchronous active-low reset; bins read as zero until first written
module best_fit_bin_allocator #(
  parameter int MAX_BINS = bfba_pkg::MAX_BINS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration writes
  input  logic                                  cfg_we,
  input  logic [bfba_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bfba_pkg::CAP_W-1:0]            cfg_wdata,
  // input word
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_action,
  input  logic [bfba_pkg::LEN_W-1:0]            in_item_length,
  // result word
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [bfba_pkg::BIN_OUT_W-1:0]        out_assigned_bin,
  output logic                                  out_placed_by,
  output logic                                  out_status,
  output logic signed [bfba_pkg::LEFT_W-1:0]    out_capacity_left
);

`include "best_fit_bin_allocator_assert.svh"

  bfba_pkg::cmd_t cmd;
  bfba_pkg::sts_t sts;

  // sequencer: idle, decide, clear sweep or scan and drain, write-back, result
  bfba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // config registers, bin store, best-fit and largest-bin trackers, output reg
  bfba_dpath #(
    .MAX_BINS (MAX_BINS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_action         (in_action),
    .in_item_length    (in_item_length),
    .out_ready         (out_ready),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_assigned_bin  (out_assigned_bin),
    .out_placed_by     (out_placed_by),
    .out_status        (out_status),
    .out_capacity_left (out_capacity_left)
  );

  // a pending result is never overwritten
  `BFBA_ASSERT_SAME(a_load_out_free, cmd.load_out, sts.out_free, "pending result overwritten")
  // only one word in flight
  `BFBA_ASSERT_NEXT(a_one_word, in_valid && in_ready, !in_ready, "word accepted while busy")
  // a result shows up only after the controller loads it
  `BFBA_ASSERT_SAME(a_out_from_load, $rose(out_valid), $past(cmd.load_out), "result without load")
  // the clear sweep never runs together with the write-back or the scan
  `BFBA_ASSERT_SAME(a_wr_excl, cmd.clr_wr, !cmd.wb && !cmd.scan_rd, "store access conflict")

endmodule

/* rtl/core/bfba_ctrl.sv */
// controller state machine of the best-fit bin allocator
module bfba_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  bfba_pkg::sts_t  sts,
  output bfba_pkg::cmd_t  cmd
);

  bfba_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfba_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      bfba_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = bfba_pkg::ST_DECIDE;
        end
      end
      bfba_pkg::ST_DECIDE: begin
        cmd.cnt_clr = 1'b1;
        if (sts.is_clear) begin
          state_nxt = bfba_pkg::ST_CLEAR;
        end else if (sts.oversize) begin
          state_nxt = bfba_pkg::ST_RESULT;
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = bfba_pkg::ST_SCAN;
        end
      end
      bfba_pkg::ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = bfba_pkg::ST_RESULT;
        end
      end
      bfba_pkg::ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = bfba_pkg::ST_DRAIN;
        end
      end
      bfba_pkg::ST_DRAIN: begin
        state_nxt = bfba_pkg::ST_WB;
      end
      bfba_pkg::ST_WB: begin
        cmd.wb    = 1'b1;
        state_nxt = bfba_pkg::ST_RESULT;
      end
      bfba_pkg::ST_RESULT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = bfba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bfba_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/bfba_dpath.sv */
// datapath of the best-fit bin allocator: config, bin store, scan and result
module bfba_dpath #(
  parameter int MAX_BINS = bfba_pkg::MAX_BINS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [bfba_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bfba_pkg::CAP_W-1:0]            cfg_wdata,
  input  logic                                  in_action,
  input  logic [bfba_pkg::LEN_W-1:0]            in_item_length,
  input  logic                                  out_ready,
  input  bfba_pkg::cmd_t                        cmd,
  output bfba_pkg::sts_t                        sts,
  output logic                                  out_valid,
  output logic [bfba_pkg::BIN_OUT_W-1:0]        out_assigned_bin,
  output logic                                  out_placed_by,
  output logic                                  out_status,
  output logic signed [bfba_pkg::LEFT_W-1:0]    out_capacity_left
);

  localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CNT_W = $clog2(MAX_BINS + 1);
  localparam int NW    = (CNT_W > bfba_pkg::COUNT_W) ? CNT_W : bfba_pkg::COUNT_W;
  localparam int LW    = bfba_pkg::LEFT_W;
  localparam int DW    = bfba_pkg::DIFF_W;

  // configuration
  logic [bfba_pkg::COUNT_W-1:0] bin_count_r;
  logic [bfba_pkg::CAP_W-1:0]   bin_cap_r;
  logic [bfba_pkg::CAP_W-1:0]   slack_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r <= bfba_pkg::BIN_COUNT_RST;
      bin_cap_r   <= '0;
      slack_r     <= '1;
    end else if (cfg_we) begin
      unique case (bfba_pkg::cfg_reg_t'(cfg_index))
        bfba_pkg::CFG_BIN_COUNT:    bin_count_r <= cfg_wdata[bfba_pkg::COUNT_W-1:0];
        bfba_pkg::CFG_BIN_CAPACITY: bin_cap_r   <= cfg_wdata;
        bfba_pkg::CFG_SLACK_LIMIT:  slack_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // active bin count, zero counts as one, saturates at the store depth
  logic [NW-1:0]    bc_ext, n_act;
  logic [IDX_W-1:0] last_idx;

  always_comb begin
    bc_ext = NW'(bin_count_r);
    if (bc_ext == '0) begin
      n_act = NW'(1);
    end else if (bc_ext > NW'(MAX_BINS)) begin
      n_act = NW'(MAX_BINS);
    end else begin
      n_act = bc_ext;
    end
    last_idx = IDX_W'(n_act - NW'(1));
  end

  // latched item
  logic                         item_action_r;
  logic [bfba_pkg::LEN_W-1:0]   item_len_r;
  logic signed [DW-1:0]         len_ext;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_action_r <= in_action;
      item_len_r    <= in_item_length;
    end
  end

  assign len_ext = $signed({{(DW-bfba_pkg::LEN_W){1'b0}}, item_len_r});

  // bin counter, shared by the clear sweep and the scan
  logic [IDX_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.clr_wr || cmd.scan_rd) begin
      cnt_nxt = cnt_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // bin store with per-entry valid bits, unwritten entries read as zero
  logic signed [LW-1:0] mem [MAX_BINS];
  logic [MAX_BINS-1:0]  vld_r;
  logic signed [LW-1:0] rd_data_r;
  logic                 rd_vld_r;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic signed [LW-1:0] wr_data;
  logic [IDX_W-1:0]     chosen;
  logic signed [LW-1:0] left;

  assign wr_en   = cmd.clr_wr || cmd.wb;
  assign wr_addr = cmd.clr_wr ? cnt_r : chosen;
  assign wr_data = cmd.clr_wr ? $signed({1'b0, bin_cap_r}) : left;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[cnt_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[cnt_r];
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  // compare stage, one bin per cycle
  logic                 cmp_en_r;
  logic [IDX_W-1:0]     cmp_idx_r;
  logic signed [LW-1:0] cur_v;
  logic signed [DW-1:0] cur_d;
  logic                 fit_ok, max_ok;
  logic signed [DW-1:0] best_d_r;
  logic [IDX_W-1:0]     best_idx_r;
  logic                 found_r;
  logic signed [LW-1:0] max_r;
  logic [IDX_W-1:0]     max_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_en_r <= 1'b0;
    end else begin
      cmp_en_r <= cmd.scan_rd;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= cnt_r;
  end

  always_comb begin
    cur_v  = rd_vld_r ? rd_data_r : '0;
    cur_d  = $signed({cur_v[LW-1], cur_v}) - len_ext;
    fit_ok = !cur_d[DW-1] && (cur_d != '0) && (cur_d < best_d_r);
    max_ok = (cmp_idx_r == '0) || (cur_v > max_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      best_d_r   <= $signed({{(DW-bfba_pkg::CAP_W){1'b0}}, slack_r});
      best_idx_r <= '0;
      found_r    <= 1'b0;
    end else if (cmp_en_r && fit_ok) begin
      best_d_r   <= cur_d;
      best_idx_r <= cmp_idx_r;
      found_r    <= 1'b1;
    end
    if (cmp_en_r && max_ok) begin
      max_r     <= cur_v;
      max_idx_r <= cmp_idx_r;
    end
  end

  // write-back value; fallback saturates at the lowest capacity
  logic signed [DW-1:0] fb_d;
  logic signed [LW-1:0] fb_left;

  always_comb begin
    fb_d    = $signed({max_r[LW-1], max_r}) - len_ext;
    fb_left = (fb_d < bfba_pkg::REM_MIN) ? bfba_pkg::REM_MIN[LW-1:0] : fb_d[LW-1:0];
    left    = found_r ? best_d_r[LW-1:0] : fb_left;
    chosen  = found_r ? best_idx_r : max_idx_r;
  end

  logic [IDX_W-1:0]     res_bin_r;
  logic                 res_fb_r;
  logic signed [LW-1:0] res_left_r;

  always_ff @(posedge clk) begin
    if (cmd.wb) begin
      res_bin_r  <= chosen;
      res_fb_r   <= found_r ? bfba_pkg::PLACED_BEST : bfba_pkg::PLACED_FALLBACK;
      res_left_r <= left;
    end
  end

  // output register
  logic oversize;
  logic out_valid_r, out_valid_nxt;
  logic [bfba_pkg::BIN_OUT_W-1:0] out_bin_r;
  logic                           out_fb_r;
  logic                           out_st_r;
  logic signed [LW-1:0]           out_left_r;

  assign oversize = {{(bfba_pkg::CAP_W-bfba_pkg::LEN_W){1'b0}}, item_len_r} > bin_cap_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (item_action_r == bfba_pkg::ACT_CLEAR) begin
        out_bin_r  <= '0;
        out_fb_r   <= bfba_pkg::PLACED_BEST;
        out_st_r   <= bfba_pkg::STATUS_OK;
        out_left_r <= '0;
      end else if (oversize) begin
        out_bin_r  <= '0;
        out_fb_r   <= bfba_pkg::PLACED_BEST;
        out_st_r   <= bfba_pkg::STATUS_OVERSIZE;
        out_left_r <= '0;
      end else begin
        out_bin_r  <= bfba_pkg::BIN_OUT_W'(res_bin_r);
        out_fb_r   <= res_fb_r;
        out_st_r   <= bfba_pkg::STATUS_OK;
        out_left_r <= res_left_r;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_assigned_bin  = out_bin_r;
  assign out_placed_by     = out_fb_r;
  assign out_status        = out_st_r;
  assign out_capacity_left = out_left_r;

  assign sts.is_clear = (item_action_r == bfba_pkg::ACT_CLEAR);
  assign sts.oversize = oversize;
  assign sts.cnt_last = (cnt_r == last_idx);
  assign sts.out_free = !out_valid_r || out_ready;

endmodule

/* tb/testbench.sv */
// self-checking testbench for the best-fit bin allocator
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // random words after the directed table
  localparam int RANDOM_WORDS = 1050;
  // words at the end sent with no random idle bursts or output stalls
  localparam int QUIET_TAIL   = 120;
  // cycles with no accepted word before the run is declared hung
  localparam int HANG_LIMIT   = 4000;
  // drain cycles after the last result
  localparam int TAIL_CYCLES  = 2 * bfba_pkg::MAX_BINS_DEF;

  typedef struct packed {
    logic [bfba_pkg::BIN_OUT_W-1:0] assigned_bin;
    logic                           placed_by;
    logic                           status;
    logic [bfba_pkg::LEFT_W-1:0]    capacity_left;
  } alloc_result_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    bfba_pkg::cfg_reg_t         reg_idx;
    logic [bfba_pkg::CAP_W-1:0] value;   // register value, or item length in the low bits
    logic                       action;
    logic                       fixed;   // result typed in below instead of predicted
    alloc_result_t              result;
  } stim_row_t;

  localparam alloc_result_t RES_ZERO     = '0;
  localparam alloc_result_t RES_OVERSIZE =
    '{4'd0, bfba_pkg::PLACED_BEST, bfba_pkg::STATUS_OVERSIZE, 41'd0};
  localparam alloc_result_t RES_EMPTY_FB =
    '{4'd0, bfba_pkg::PLACED_FALLBACK, bfba_pkg::STATUS_OK, 41'd0};
  localparam logic [bfba_pkg::CAP_W-1:0] CAP_MAX = {bfba_pkg::CAP_W{1'b1}};
  localparam logic [bfba_pkg::CAP_W-1:0] LEN_MAX = 40'h00_FFFF_FFFF;
  // all-ones length, the longest item the port carries
  localparam logic [bfba_pkg::LEN_W-1:0] LEN_LIMIT_ALL = {bfba_pkg::LEN_W{1'b1}};

  logic                                 clk;
  logic                                 rst_n;
  logic                                 cfg_we;
  logic [bfba_pkg::CFG_IDX_W-1:0]       cfg_index;
  logic [bfba_pkg::CAP_W-1:0]           cfg_wdata;
  logic                                 in_valid;
  logic                                 in_ready;
  logic                                 in_action;
  logic [bfba_pkg::LEN_W-1:0]           in_item_length;
  logic                                 out_valid;
  logic                                 out_ready;
  logic [bfba_pkg::BIN_OUT_W-1:0]       out_assigned_bin;
  logic                                 out_placed_by;
  logic                                 out_status;
  logic signed [bfba_pkg::LEFT_W-1:0]   out_capacity_left;

  // typed-in result travels with the word, driven like the payload
  logic                                 word_fixed;
  alloc_result_t                        word_fixed_result;

  // predictor state: register copies and per-bin remaining capacity
  logic [bfba_pkg::COUNT_W-1:0]         count_q;
  logic [bfba_pkg::CAP_W-1:0]           capacity_q;
  logic [bfba_pkg::CAP_W-1:0]           slack_q;
  logic signed [bfba_pkg::DIFF_W-1:0]   bin_left_q [bfba_pkg::MAX_BINS_DEF];

  alloc_result_t                        pending_allocs [$];
  int                                   errors;
  int                                   hang_cycles;
  bit                                   quiet;

  // directed part: extremes, both actions, the corner cases of the search
  stim_row_t directed_rows [28] = '{
    // after reset: capacity 0, all bins empty, so a zero length falls back to bin 0
    '{ROW_WORD, bfba_pkg::CFG_BIN_COUNT, 40'd0, bfba_pkg::ACT_PLACE, 1'b1, RES_EMPTY_FB},
    '{ROW_WORD, bfba_pkg::CFG_BIN_COUNT, 40'd1, bfba_pkg::ACT_PLACE, 1'b1, RES_OVERSIZE},
    '{ROW_WORD, bfba_pkg::CFG_BIN_COUNT, LEN_MAX, bfba_pkg::ACT_PLACE, 1'b1, RES_OVERSIZE},
    '{ROW_WORD, bfba_pkg::CFG_BIN_COUNT, LEN_MAX, bfba_pkg::ACT_CLEAR, 1'b1, RES_ZERO},
    // largest capacity, longest item
    '{ROW_CFG,  bfba_pkg::CFG_BIN_CAPACITY, CAP_MAX, bfba_pkg::ACT_CLEAR, 1'b0, RES_ZERO},
    '{ROW_WORD, bfba_pkg::CFG_BIN_COUNT, 40'd0, bfba_pkg::ACT_CLEAR, 1'b1, RES_ZERO},
    '{ROW_WORD, bfba_pkg::CFG_BIN_COUNT, LEN_MAX, bfba_pkg::ACT_PLACE, 1'b0, RES_ZERO},
    '{ROW_WORD, bfba_pkg::CFG_BIN_COUNT, 40'd0, bfba_pkg::ACT_PLACE, 1'b0, RES_ZERO},
    // no best fit possible: fallback, ties go to the lowest bin
    '{ROW_CFG,  bfba_pkg::CFG_SLACK_LIMIT, 40'd0, bfba_pkg::ACT_CLEAR, 1'b0, RES_ZERO},
    '{ROW_WORD, bfba_pkg::CFG_BIN_COUNT, 40'd5, bfba_pkg::ACT_PLACE, 1'b0, RES_ZERO},
    // count zero acts as one bin
    '{ROW_CFG,  bfba_pkg::CFG_BIN_COUNT, 40'd0, bfba_pkg::ACT_CLEAR, 1'b0, RES_ZERO},
    '{ROW_WORD, bfba_pkg::CFG_BIN_COUNT, 40'd7, bfba_pkg::ACT_PLACE, 1'b0, RES_ZERO},
    // count above the bin store saturates, upper bins still hold reset values
    '{ROW_CFG,  bfba_pkg::CFG_BIN_COUNT, 40'd31, bfba_pkg::ACT_CLEAR, 1'b0, RES_ZERO},
    '{ROW_WORD, bfba_pkg::CFG_BIN_COUNT, 40'd3, bfba_pkg::ACT_PLACE, 1'b0, RES_ZERO},
    '{ROW_WORD, bfba_pkg::CFG_BIN_COUNT, 40'd9, bfba_pkg::ACT_CLEAR, 1'b1, RES_ZERO},
    '{ROW_CFG,  bfba_pkg::CFG_SLACK_LIMIT, 40'd1, bfba_pkg::ACT_CLEAR, 1'b0, RES_ZERO},
    '{ROW_WORD, bfba_pkg::CFG_BIN_COUNT, 40'd100, bfba_pkg::ACT_PLACE, 1'b0, RES_ZERO},
    // two small bins: tight best fits, tie in the fallback, going negative
    '{ROW_CFG,  bfba_pkg::CFG_BIN_COUNT, 40'd2, bfba_pkg::ACT_CLEAR, 1'b0, RES_ZERO},
    '{ROW_CFG,  bfba_pkg::CFG_BIN_CAPACITY, 40'd10, bfba_pkg::ACT_CLEAR, 1'b0, RES_ZERO},
    '{ROW_CFG,  bfba_pkg::CFG_SLACK_LIMIT, 40'd2, bfba_pkg::ACT_CLEAR, 1'b0, RES_ZERO},
    '{ROW_WORD, bfba_pkg::CFG_BIN_COUNT, 40'd0, bfba_pkg::ACT_CLEAR, 1'b1, RES_ZERO},
    '{ROW_WORD, bfba_pkg::CFG_BIN_COUNT, 40'd9, bfba_pkg::ACT_PLACE, 1'b0, RES_ZERO},
    '{ROW_WORD, bfba_pkg::CFG_BIN_COUNT, 40'd9, bfba_pkg::ACT_PLACE, 1'b0, RES_ZERO},
    '{ROW_WORD, bfba_pkg::CFG_BIN_COUNT, 40'd1, bfba_pkg::ACT_PLACE, 1'b0, RES_ZERO},
    '{ROW_WORD, bfba_pkg::CFG_BIN_COUNT, 40'd10, bfba_pkg::ACT_PLACE, 1'b0, RES_ZERO},
    '{ROW_WORD, bfba_pkg::CFG_BIN_COUNT, 40'd11, bfba_pkg::ACT_PLACE, 1'b1, RES_OVERSIZE},
    '{ROW_WORD, bfba_pkg::CFG_BIN_COUNT, 40'd0, bfba_pkg::ACT_PLACE, 1'b0, RES_ZERO},
    '{ROW_CFG,  bfba_pkg::CFG_BIN_COUNT, 40'd16, bfba_pkg::ACT_CLEAR, 1'b0, RES_ZERO}
  };

  best_fit_bin_allocator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_item_length    (in_item_length),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_assigned_bin  (out_assigned_bin),
    .out_placed_by     (out_placed_by),
    .out_status        (out_status),
    .out_capacity_left (out_capacity_left)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // best-fit search over the active bins, updates the predicted bin store
  function automatic alloc_result_t allocate(input logic action,
                                             input logic [bfba_pkg::LEN_W-1:0] len);
    alloc_result_t                      res;
    int                                 active;
    int                                 chosen;
    logic                               found;
    logic signed [bfba_pkg::DIFF_W-1:0] len_s;
    logic signed [bfba_pkg::DIFF_W-1:0] diff;
    logic signed [bfba_pkg::DIFF_W-1:0] best;
    logic signed [bfba_pkg::DIFF_W-1:0] top;
    logic signed [bfba_pkg::DIFF_W-1:0] left;
    res    = RES_ZERO;
    active = (count_q == 0) ? 1 :
             (int'(count_q) > bfba_pkg::MAX_BINS_DEF) ? bfba_pkg::MAX_BINS_DEF : int'(count_q);
    if (action == bfba_pkg::ACT_CLEAR) begin
      for (int i = 0; i < active; i++) bin_left_q[i] = $signed({2'b00, capacity_q});
      return res;
    end
    // longer than a fresh bin: flagged, nothing changes
    if ({{(bfba_pkg::CAP_W-bfba_pkg::LEN_W){1'b0}}, len} > capacity_q) begin
      res.status = bfba_pkg::STATUS_OVERSIZE;
      return res;
    end
    len_s  = $signed({{(bfba_pkg::DIFF_W-bfba_pkg::LEN_W){1'b0}}, len});
    best   = $signed({2'b00, slack_q});
    found  = 1'b0;
    chosen = 0;
    for (int i = 0; i < active; i++) begin
      diff = bin_left_q[i] - len_s;
      if (diff > 0 && diff < best) begin
        best   = diff;
        chosen = i;
        found  = 1'b1;
      end
    end
    // no tight fit: take the roomiest bin, first one on a tie
    if (!found) begin
      top = bin_left_q[0];
      for (int i = 1; i < active; i++) begin
        if (bin_left_q[i] > top) begin
          top    = bin_left_q[i];
          chosen = i;
        end
      end
      res.placed_by = bfba_pkg::PLACED_FALLBACK;
    end
    left = bin_left_q[chosen] - len_s;
    if (left < bfba_pkg::REM_MIN) left = bfba_pkg::REM_MIN;
    bin_left_q[chosen]  = left;
    res.assigned_bin    = chosen[bfba_pkg::BIN_OUT_W-1:0];
    res.capacity_left   = left[bfba_pkg::LEFT_W-1:0];
    return res;
  endfunction

  task automatic report(input string field, input logic [63:0] want, input logic [63:0] got);
    errors++;
    $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endtask

  // scoreboard: predict on input accept, compare on output accept, mirror config writes
  always @(posedge clk) begin : scoreboard
    alloc_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_allocs.size() == 0) begin
          errors++;
          $display("%0t ns: result word with nothing expected, bin %0d", $time, out_assigned_bin);
        end else begin
          want = pending_allocs.pop_front();
          if (out_assigned_bin !== want.assigned_bin)
            report("assigned_bin", 64'(want.assigned_bin), 64'(out_assigned_bin));
          if (out_placed_by !== want.placed_by)
            report("placed_by", 64'(want.placed_by), 64'(out_placed_by));
          if (out_status !== want.status)
            report("status", 64'(want.status), 64'(out_status));
          if (out_capacity_left !== want.capacity_left)
            report("capacity_left", 64'(want.capacity_left),
                   64'($unsigned(out_capacity_left)));
        end
      end
      if (in_valid && in_ready) begin
        want = allocate(in_action, in_item_length);
        pending_allocs.insert(pending_allocs.size(), word_fixed ? word_fixed_result : want);
      end
      if (cfg_we) begin
        case (cfg_index)
          bfba_pkg::CFG_BIN_COUNT:    count_q    = cfg_wdata[bfba_pkg::COUNT_W-1:0];
          bfba_pkg::CFG_BIN_CAPACITY: capacity_q = cfg_wdata;
          bfba_pkg::CFG_SLACK_LIMIT:  slack_q    = cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      hang_cycles <= 0;
    end else begin
      hang_cycles <= hang_cycles + 1;
      if (hang_cycles >= HANG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // result side: random stall bursts, none in the quiet tail
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // present one word, optionally after an idle burst, and hold it until accepted
  task automatic send_word(input logic action, input logic [bfba_pkg::LEN_W-1:0] len,
                           input logic fixed, input alloc_result_t result);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_action         <= action;
    in_item_length    <= len;
    word_fixed        <= fixed;
    word_fixed_result <= result;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop sending and wait until every predicted result has come back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_allocs.size() != 0);
  endtask

  task automatic write_reg(input bfba_pkg::cfg_reg_t idx,
                           input logic [bfba_pkg::CAP_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    int                           random_words;
    int                           phase;
    int                           span;
    int                           pick;
    bit                           drain;
    logic [bfba_pkg::COUNT_W-1:0] count;
    logic [bfba_pkg::CAP_W-1:0]   capacity;
    logic [bfba_pkg::CAP_W-1:0]   slack;
    logic [bfba_pkg::LEN_W-1:0]   fit_max;
    logic [63:0]                  len64;
    logic                         action;

    // every input known from time zero
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = bfba_pkg::CFG_BIN_COUNT;
    cfg_wdata         = '0;
    in_valid          = 1'b0;
    in_action         = bfba_pkg::ACT_CLEAR;
    in_item_length    = '0;
    word_fixed        = 1'b0;
    word_fixed_result = RES_ZERO;
    errors            = 0;
    hang_cycles       = 0;
    quiet             = 1'b0;
    // predictor reset state
    count_q           = bfba_pkg::BIN_COUNT_RST;
    capacity_q        = '0;
    slack_q           = CAP_MAX;
    foreach (bin_left_q[i]) bin_left_q[i] = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
      end else begin
        send_word(directed_rows[i].action, directed_rows[i].value[bfba_pkg::LEN_W-1:0],
                  directed_rows[i].fixed, directed_rows[i].result);
      end
    end

    // random phases, each with its own register setting
    random_words = 0;
    phase        = 0;
    while (random_words < RANDOM_WORDS) begin
      // one phase drives a single bin deep negative until it saturates
      drain = (phase == 2);
      case ($urandom_range(0, 4))
        0:       count = '0;
        1:       count = 5'd1;
        2:       count = 5'($urandom_range(2, 16));
        3:       count = 5'd16;
        default: count = 5'($urandom_range(17, 31));
      endcase
      case ($urandom_range(0, 5))
        0, 1:    capacity = 40'($urandom_range(0, 40));
        2:       capacity = 40'($urandom);
        3:       capacity = LEN_MAX;
        4:       capacity = {8'($urandom), 32'($urandom)};
        default: capacity = CAP_MAX;
      endcase
      case ($urandom_range(0, 5))
        0:       slack = '0;
        1:       slack = 40'd1;
        2:       slack = 40'($urandom_range(2, 50));
        3:       slack = {8'($urandom), 32'($urandom)};
        4:       slack = capacity >> $urandom_range(0, 8);
        default: slack = CAP_MAX;
      endcase
      if (drain) begin
        count    = 5'($urandom_range(0, 1));
        capacity = LEN_MAX;
      end
      settle();
      // upper data bits of the count write are junk on purpose
      write_reg(bfba_pkg::CFG_BIN_COUNT, {8'($urandom), 27'($urandom), count});
      write_reg(bfba_pkg::CFG_BIN_CAPACITY, capacity);
      write_reg(bfba_pkg::CFG_SLACK_LIMIT, slack);

      fit_max = (capacity > LEN_MAX) ? LEN_LIMIT_ALL : capacity[bfba_pkg::LEN_W-1:0];
      if (drain || $urandom_range(0, 9) != 0) begin
        send_word(bfba_pkg::ACT_CLEAR, $urandom, 1'b0, RES_ZERO);
        random_words++;
      end
      span = drain ? 280 : $urandom_range(20, 60);
      for (int k = 0; k < span; k++) begin
        if (random_words >= RANDOM_WORDS - QUIET_TAIL) quiet = 1'b1;
        pick   = $urandom_range(0, 99);
        action = bfba_pkg::ACT_PLACE;
        if (drain) begin
          len64 = LEN_MAX;
        end else if (pick < 6) begin
          action = bfba_pkg::ACT_CLEAR;
          len64  = 64'($urandom);
        end else if (pick < 14) begin
          // longer than the capacity where the length field allows it
          if (capacity < LEN_MAX)
            len64 = 64'(capacity) + 64'd1 + (64'($urandom) % (64'(LEN_MAX) - 64'(capacity)));
          else
            len64 = LEN_MAX;
        end else if (pick < 20) begin
          len64 = $urandom_range(0, 1) ? 64'(fit_max) : 64'd0;
        end else begin
          len64 = {32'($urandom), 32'($urandom)} % (64'(fit_max) + 64'd1);
        end
        send_word(action, len64[bfba_pkg::LEN_W-1:0], 1'b0, RES_ZERO);
        random_words++;
      end
      phase++;
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending_allocs.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/bfba_pkg.sv
rtl/core/bfba_ctrl.sv
rtl/core/bfba_dpath.sv
rtl/core/best_fit_bin_allocator.sv
tb/testbench.sv
